/* src/vfc_pkg.sv */
// Package for the volume fade controller: widths, codes, state types.
package vfc_pkg;

    localparam int GAIN_BITS = 16;
    localparam int TIME_BITS = 16;
    localparam int PROD_BITS = GAIN_BITS + TIME_BITS;
    localparam int DIV_CNT_W = $clog2(GAIN_BITS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(GAIN_BITS - 1);

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_PLAY       = 3'd1,
        CMD_STOP       = 3'd2,
        CMD_FORCE_STOP = 3'd3,
        CMD_PAUSE      = 3'd4,
        CMD_RESUME     = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_INIT     = 3'd0,
        MODE_PLAYING  = 3'd1,
        MODE_FADE_IN  = 3'd2,
        MODE_FADE_OUT = 3'd3,
        MODE_PAUSE    = 3'd4,
        MODE_END      = 3'd5,
        MODE_ERROR    = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_MUL  = 2'd1,
        SEQ_DIV  = 2'd2,
        SEQ_OUT  = 2'd3
    } seq_state_t;

    // Flags of one result that do not come from the state registers
    typedef struct packed {
        logic gain_write;
        logic ok;
        logic start_stream;
        logic stop_stream;
        logic pause_stream;
        logic resume_stream;
    } res_flags_t;

endpackage

/* src/vfc_if.sv */
// Channel interfaces of the volume fade controller: command, result, configuration.
interface vfc_cmd_if import vfc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [2:0]           command;
    logic [TIME_BITS-1:0] fade_length;
    logic [TIME_BITS-1:0] elapsed;
    logic                 start_ok;

    modport source (output valid, command, fade_length, elapsed, start_ok, input ready);
    modport sink   (input valid, command, fade_length, elapsed, start_ok, output ready);
endinterface

interface vfc_res_if import vfc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [GAIN_BITS-1:0] gain;
    logic                 gain_write;
    logic [2:0]           mode_now;
    logic                 ok;
    logic                 start_stream;
    logic                 stop_stream;
    logic                 pause_stream;
    logic                 resume_stream;
    logic                 tick_enabled;

    modport source (output valid, gain, gain_write, mode_now, ok, start_stream, stop_stream,
                    pause_stream, resume_stream, tick_enabled, input ready);
    modport sink   (input valid, gain, gain_write, mode_now, ok, start_stream, stop_stream,
                    pause_stream, resume_stream, tick_enabled, output ready);
endinterface

interface vfc_cfg_if import vfc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [GAIN_BITS-1:0] target_gain;

    modport source (output valid, target_gain, input ready);
    modport sink   (input valid, target_gain, output ready);
endinterface

/* src/volume_fade_controller.sv */
// Top level: playback gain controller with a linear fade envelope and a serial divider.
//
//  channel | dir | handshake   | payload
//  cmd     | in  | valid/ready | command, fade_length, elapsed, start_ok
//  res     | out | valid/ready | gain, gain_write, mode_now, ok, engine requests, tick_enabled
//  cfg     | in  | valid/ready | target_gain (ready always high)
//
// A tick inside a fade that needs a ramp value passes one multiply, GAIN_BITS restoring
// divide steps and one output load after accept; every other command goes from accept
// straight to the output load. One item is in work at a time; a result waits in the
// output register while the next item is taken. A full output register holds the
// sequencer in its output step until the sink takes the waiting result. No clearing
// pass follows reset.
module volume_fade_controller import vfc_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    vfc_cmd_if.sink   cmd,
    vfc_res_if.source res,
    vfc_cfg_if.sink   cfg
);

    // Architectural state
    logic [GAIN_BITS-1:0] target_reg;
    mode_t                mode_reg, mode_next;
    logic [TIME_BITS:0]   timer_reg, timer_next;
    logic [TIME_BITS-1:0] total_reg, total_next;
    logic                 valid_stream_reg, valid_stream_next;
    logic                 ticking_reg, ticking_next;

    // Sequencer and divider
    seq_state_t           state_reg, state_next;
    res_flags_t           flags_reg, flags_next;
    logic [TIME_BITS-1:0] op_reg, op_next;
    logic [TIME_BITS-1:0] rem_reg;
    logic [GAIN_BITS-1:0] low_reg;
    logic [GAIN_BITS-1:0] direct_gain;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 need_div;
    logic [PROD_BITS-1:0] product;
    logic [TIME_BITS:0]   trial;
    logic                 trial_ge;

    // Output register
    logic                 out_valid_reg;
    logic [GAIN_BITS-1:0] out_gain_reg;
    res_flags_t           out_flags_reg;
    mode_t                out_mode_reg;
    logic                 out_tick_reg;
    logic                 out_load;

    // Tick arithmetic
    logic [TIME_BITS+1:0] timer_sum;
    logic [TIME_BITS:0]   timer_sat;
    logic                 sat_ge_total;
    logic                 sat_gt_total;
    logic                 accept;
    logic                 stream_now;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == SEQ_IDLE);
    assign cfg.ready = 1'b1;
    assign out_load  = (state_reg == SEQ_OUT) && (!out_valid_reg || res.ready);

    // Saturating timer advance and its compares against the fade total
    assign timer_sum    = {1'b0, timer_reg} + {2'b00, cmd.elapsed};
    assign timer_sat    = timer_sum[TIME_BITS+1] ? {(TIME_BITS+1){1'b1}} : timer_sum[TIME_BITS:0];
    assign sat_ge_total = (timer_sat >= {1'b0, total_reg});
    assign sat_gt_total = (timer_sat >  {1'b0, total_reg});

    // Decode one command into the next state and the result flags
    always_comb
    begin
        mode_next         = mode_reg;
        timer_next        = timer_reg;
        total_next        = total_reg;
        valid_stream_next = valid_stream_reg;
        ticking_next      = ticking_reg;
        flags_next        = '0;
        flags_next.ok     = 1'b1;
        direct_gain       = '0;
        need_div          = 1'b0;
        op_next           = '0;
        stream_now        = valid_stream_reg;
        unique case (cmd.command)
            CMD_TICK:
            begin
                if (ticking_reg)
                begin
                    if (!valid_stream_reg)
                    begin
                        mode_next    = MODE_ERROR;
                        ticking_next = 1'b0;
                    end
                    else
                    begin
                        timer_next = timer_sat;
                        if (mode_reg == MODE_FADE_IN)
                        begin
                            flags_next.gain_write = 1'b1;
                            if (sat_ge_total)
                                direct_gain = target_reg;
                            else
                            begin
                                need_div = 1'b1;
                                op_next  = timer_sat[TIME_BITS-1:0];
                            end
                            if (sat_gt_total)
                            begin
                                mode_next    = MODE_PLAYING;
                                ticking_next = 1'b0;
                            end
                        end
                        else if (mode_reg == MODE_FADE_OUT)
                        begin
                            flags_next.gain_write = 1'b1;
                            if (!sat_ge_total)
                            begin
                                need_div = 1'b1;
                                op_next  = total_reg - timer_sat[TIME_BITS-1:0];
                            end
                            if (sat_gt_total)
                            begin
                                flags_next.stop_stream = 1'b1;
                                mode_next              = MODE_END;
                                ticking_next           = 1'b0;
                            end
                        end
                        else
                        begin
                            mode_next    = MODE_ERROR;
                            ticking_next = 1'b0;
                        end
                    end
                end
            end
            CMD_PLAY:
            begin
                if (mode_reg != MODE_PLAYING && mode_reg != MODE_FADE_IN)
                begin
                    if (mode_reg != MODE_FADE_OUT)
                    begin
                        flags_next.start_stream = 1'b1;
                        stream_now              = cmd.start_ok;
                    end
                    valid_stream_next = stream_now;
                    if (!stream_now)
                    begin
                        mode_next     = MODE_ERROR;
                        ticking_next  = 1'b0;
                        flags_next.ok = 1'b0;
                    end
                    else
                    begin
                        flags_next.gain_write = 1'b1;
                        if (cmd.fade_length != '0)
                        begin
                            timer_next   = '0;
                            total_next   = cmd.fade_length;
                            mode_next    = MODE_FADE_IN;
                            ticking_next = 1'b1;
                        end
                        else
                        begin
                            direct_gain  = target_reg;
                            mode_next    = MODE_PLAYING;
                            ticking_next = 1'b0;
                        end
                    end
                end
            end
            CMD_STOP:
            begin
                if (mode_reg != MODE_PLAYING && mode_reg != MODE_FADE_IN &&
                    mode_reg != MODE_FADE_OUT)
                    mode_next = MODE_END;
                else if (!valid_stream_reg)
                begin
                    mode_next    = MODE_ERROR;
                    ticking_next = 1'b0;
                end
                else if (cmd.fade_length == '0)
                begin
                    mode_next              = MODE_END;
                    flags_next.stop_stream = 1'b1;
                end
                else
                begin
                    if (mode_reg != MODE_FADE_OUT)
                        timer_next = '0;
                    mode_next    = MODE_FADE_OUT;
                    total_next   = cmd.fade_length;
                    ticking_next = 1'b1;
                end
            end
            CMD_FORCE_STOP:
            begin
                mode_next              = MODE_END;
                flags_next.stop_stream = valid_stream_reg;
                ticking_next           = 1'b0;
            end
            CMD_PAUSE:
            begin
                mode_next               = MODE_PAUSE;
                flags_next.pause_stream = valid_stream_reg;
            end
            CMD_RESUME:
            begin
                mode_next                = MODE_PLAYING;
                flags_next.resume_stream = valid_stream_reg;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                    state_next = need_div ? SEQ_MUL : SEQ_OUT;
            end
            SEQ_MUL:
                state_next = SEQ_DIV;
            SEQ_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                    state_next = SEQ_OUT;
            end
            SEQ_OUT:
            begin
                if (out_load)
                    state_next = SEQ_IDLE;
            end
            default:
                state_next = SEQ_IDLE;
        endcase
    end

    // Divider datapath: one multiply, then one restoring step per cycle
    assign product  = PROD_BITS'(target_reg) * PROD_BITS'(op_reg);
    assign trial    = {rem_reg, low_reg[GAIN_BITS-1]};
    assign trial_ge = (trial >= {1'b0, total_reg});

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= SEQ_IDLE;
            mode_reg         <= MODE_INIT;
            timer_reg        <= '0;
            total_reg        <= '0;
            valid_stream_reg <= 1'b0;
            ticking_reg      <= 1'b0;
            target_reg       <= '1;
            out_valid_reg    <= 1'b0;
            cnt_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
                target_reg <= cfg.target_gain;
            if (accept)
            begin
                mode_reg         <= mode_next;
                timer_reg        <= timer_next;
                total_reg        <= total_next;
                valid_stream_reg <= valid_stream_next;
                ticking_reg      <= ticking_next;
            end
            if (state_reg == SEQ_MUL)
                cnt_reg <= '0;
            else if (state_reg == SEQ_DIV)
                cnt_reg <= cnt_reg + 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Advance the payload and divider registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            flags_reg <= flags_next;
            op_reg    <= op_next;
            low_reg   <= direct_gain;
        end
        else if (state_reg == SEQ_MUL)
        begin
            rem_reg <= product[PROD_BITS-1:GAIN_BITS];
            low_reg <= product[GAIN_BITS-1:0];
        end
        else if (state_reg == SEQ_DIV)
        begin
            rem_reg <= trial_ge ? TIME_BITS'(trial - {1'b0, total_reg}) : trial[TIME_BITS-1:0];
            low_reg <= {low_reg[GAIN_BITS-2:0], trial_ge};
        end
        if (out_load)
        begin
            out_gain_reg  <= low_reg;
            out_flags_reg <= flags_reg;
            out_mode_reg  <= mode_reg;
            out_tick_reg  <= ticking_reg;
        end
    end

    // Drive the result channel
    assign res.valid         = out_valid_reg;
    assign res.gain          = out_gain_reg;
    assign res.gain_write    = out_flags_reg.gain_write;
    assign res.mode_now      = out_mode_reg;
    assign res.ok            = out_flags_reg.ok;
    assign res.start_stream  = out_flags_reg.start_stream;
    assign res.stop_stream   = out_flags_reg.stop_stream;
    assign res.pause_stream  = out_flags_reg.pause_stream;
    assign res.resume_stream = out_flags_reg.resume_stream;
    assign res.tick_enabled  = out_tick_reg;

`ifndef ASSERT_OFF
    // The scheduler only runs on a valid stream
    a_tick_needs_stream: assert property (@(posedge clk) disable iff (!rst_n)
        ticking_reg |-> valid_stream_reg)
        else $error("scheduler running without a valid stream");

    // The error mode always has the scheduler stopped
    a_error_stops_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_ERROR) |-> !ticking_reg)
        else $error("scheduler running in error mode");

    // The divider runs its full step count before the result is loaded
    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_DIV && cnt_reg != DIV_LAST) |=> (state_reg == SEQ_DIV))
        else $error("divider left early");

    // No second item is taken right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !cmd.ready)
        else $error("item taken while another is in work");
`endif

endmodule
